FILE: rtl/core/tri_pkg.sv
package tri_pkg;

   localparam int NUM_AXES = 3;
   localparam int NUM_CORNERS = 8;
   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_ONE,
      SEL_DIV
   } frac_sel_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_LOWER_X = 3'd0,
      CSR_UPPER_X = 3'd1,
      CSR_LOWER_Y = 3'd2,
      CSR_UPPER_Y = 3'd3,
      CSR_LOWER_Z = 3'd4,
      CSR_UPPER_Z = 3'd5,
      CSR_TOLERANCE = 3'd6,
      CSR_UNUSED = 3'd7
   } csr_reg_type;

endpackage

FILE: rtl/core/tri_div.sv
module tri_div #(
   parameter int W = 32,
   parameter int F = 16,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [W-1:0]  in_num [tri_pkg::NUM_AXES],
   input  logic [W-1:0]  in_den [tri_pkg::NUM_AXES],
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [F-1:0]  out_quo [tri_pkg::NUM_AXES],
   output logic [PW-1:0] out_pay
);

   logic          valid_ff [F];
   logic [PW-1:0] pay_ff [F];
   logic [W-1:0]  rem_ff [F][tri_pkg::NUM_AXES];
   logic [W-1:0]  den_ff [F][tri_pkg::NUM_AXES];
   logic [F-1:0]  quo_ff [F][tri_pkg::NUM_AXES];

   for (genvar k = 0; k < F; k++) begin : g_step
      logic          cur_valid;
      logic [PW-1:0] cur_pay;
      logic [W-1:0]  cur_rem [tri_pkg::NUM_AXES];
      logic [W-1:0]  cur_den [tri_pkg::NUM_AXES];
      logic [F-1:0]  cur_quo [tri_pkg::NUM_AXES];

      if (k == 0) begin : g_first
         always_comb begin
            cur_valid = in_valid;
            cur_pay = in_pay;
            for (int a = 0; a < tri_pkg::NUM_AXES; a++) begin
               cur_rem[a] = in_num[a];
               cur_den[a] = in_den[a];
               cur_quo[a] = '0;
            end
         end
      end else begin : g_next
         always_comb begin
            cur_valid = valid_ff[k-1];
            cur_pay = pay_ff[k-1];
            for (int a = 0; a < tri_pkg::NUM_AXES; a++) begin
               cur_rem[a] = rem_ff[k-1][a];
               cur_den[a] = den_ff[k-1][a];
               cur_quo[a] = quo_ff[k-1][a];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= cur_valid;
         end
      end

      always_ff @(posedge clock) begin
         logic [W:0] sh;
         logic       ge;
         if (en) begin
            pay_ff[k] <= cur_pay;
            for (int a = 0; a < tri_pkg::NUM_AXES; a++) begin
               sh = {cur_rem[a], 1'b0};
               ge = sh >= {1'b0, cur_den[a]};
               rem_ff[k][a] <= ge ? W'(sh - {1'b0, cur_den[a]}) : sh[W-1:0];
               den_ff[k][a] <= cur_den[a];
               quo_ff[k][a] <= {cur_quo[a][F-2:0], ge};
            end
         end
      end
   end

   assign out_valid = valid_ff[F-1];
   assign out_pay = pay_ff[F-1];
   always_comb begin
      for (int a = 0; a < tri_pkg::NUM_AXES; a++) begin
         out_quo[a] = quo_ff[F-1][a];
      end
   end

endmodule

FILE: rtl/core/tri_lerp.sv
module tri_lerp #(
   parameter int W = 32,
   parameter int F = 16,
   parameter int LANES = 1,
   parameter int PW = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [W-1:0] in_a [LANES],
   input  logic signed [W-1:0] in_b [LANES],
   input  logic [F:0]          in_f,
   input  logic [PW-1:0]       in_pay,
   output logic                out_valid,
   output logic signed [W-1:0] out_r [LANES],
   output logic [PW-1:0]       out_pay
);

   localparam logic signed [W+F+1:0] HALF = (W+F+2)'(1) <<< (F-1);

   logic                  v1_ff, v2_ff, v3_ff;
   logic [PW-1:0]         pay1_ff, pay2_ff, pay3_ff;
   logic [F:0]            f1_ff;
   logic signed [W:0]     d1_ff [LANES];
   logic signed [W-1:0]   a1_ff [LANES];
   logic signed [W-1:0]   a2_ff [LANES];
   logic signed [W+F+1:0] p2_ff [LANES];
   logic signed [W-1:0]   r3_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic signed [W+F+1:0] acc;
      if (en) begin
         pay1_ff <= in_pay;
         pay2_ff <= pay1_ff;
         pay3_ff <= pay2_ff;
         f1_ff <= in_f;
         for (int i = 0; i < LANES; i++) begin
            d1_ff[i] <= (W+1)'(in_b[i]) - (W+1)'(in_a[i]);
            a1_ff[i] <= in_a[i];
            p2_ff[i] <= (W+F+2)'(d1_ff[i]) * (W+F+2)'($signed({1'b0, f1_ff}));
            a2_ff[i] <= a1_ff[i];
            acc = (W+F+2)'($signed({a2_ff[i], {F{1'b0}}})) + p2_ff[i] + HALF;
            r3_ff[i] <= acc[W+F-1:F];
         end
      end
   end

   assign out_valid = v3_ff;
   assign out_pay = pay3_ff;
   assign out_r = r3_ff;

endmodule

FILE: rtl/core/trilinear_interpolator_top.sv
// Trilinear interpolator over one grid cell.
// Request channel (req_*): eight corner values and a query point, Q16.16.
// Response channel (rsp_*): the blended value and a range error flag; on a
// range error the value is zero.
// Both channels use valid/stall; a request is taken when valid is high and
// stall is low. Cell bounds and the range tolerance sit in the csr_* port.
// A request passes through normalising and range test, the fraction divider
// (one quotient bit per stage), fraction select, the lerp levels on x, y and z
// and the output register. One request is accepted every cycle while the
// response is not stalled.
// When the response is stalled the whole pipeline holds and req_stall rises
// in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits and loads the default cell 0..1.0 on each axis
// with a tolerance of one LSB.
// Write the csr registers only while the pipeline is empty.
module trilinear_interpolator_top #(
   parameter int DATA_WIDTH = 32,
   parameter int FRACTION_BITS = 16,
   localparam int CSR_WIDTH = (DATA_WIDTH > 32) ? 64 : 32,
   localparam int ADDR_WIDTH = (DATA_WIDTH > 32) ? 6 : 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [DATA_WIDTH-1:0] req_corner_xlo_ylo_zlo,
   input  logic signed [DATA_WIDTH-1:0] req_corner_xhi_ylo_zlo,
   input  logic signed [DATA_WIDTH-1:0] req_corner_xhi_ylo_zhi,
   input  logic signed [DATA_WIDTH-1:0] req_corner_xlo_ylo_zhi,
   input  logic signed [DATA_WIDTH-1:0] req_corner_xlo_yhi_zlo,
   input  logic signed [DATA_WIDTH-1:0] req_corner_xhi_yhi_zlo,
   input  logic signed [DATA_WIDTH-1:0] req_corner_xhi_yhi_zhi,
   input  logic signed [DATA_WIDTH-1:0] req_corner_xlo_yhi_zhi,
   input  logic signed [DATA_WIDTH-1:0] req_point_x,
   input  logic signed [DATA_WIDTH-1:0] req_point_y,
   input  logic signed [DATA_WIDTH-1:0] req_point_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_interpolated,
   output logic                         rsp_range_error,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [ADDR_WIDTH-1:0]        csr_paddr,
   input  logic [CSR_WIDTH-1:0]         csr_pwdata,
   output logic [CSR_WIDTH-1:0]         csr_prdata,
   output logic                         csr_pready
);

   localparam int W = DATA_WIDTH;
   localparam int F = FRACTION_BITS;
   localparam int NA = tri_pkg::NUM_AXES;
   localparam int NC = tri_pkg::NUM_CORNERS;
   localparam int PW = NC * W + 2 * NA + 1;
   localparam int YPW = 2 * (F + 1) + 1;
   localparam int ZPW = (F + 1) + 1;

   logic signed [W-1:0] cfg_lo_ff [NA];
   logic signed [W-1:0] cfg_hi_ff [NA];
   logic [F-1:0]        cfg_tol_ff;
   tri_pkg::csr_reg_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_idx = tri_pkg::csr_reg_type'(csr_paddr[ADDR_WIDTH-1:ADDR_WIDTH-3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NA; a++) begin
            cfg_lo_ff[a] <= '0;
            cfg_hi_ff[a] <= W'(1) <<< F;
         end
         cfg_tol_ff <= F'(1);
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_idx)
            tri_pkg::CSR_LOWER_X: cfg_lo_ff[0] <= csr_pwdata[W-1:0];
            tri_pkg::CSR_UPPER_X: cfg_hi_ff[0] <= csr_pwdata[W-1:0];
            tri_pkg::CSR_LOWER_Y: cfg_lo_ff[1] <= csr_pwdata[W-1:0];
            tri_pkg::CSR_UPPER_Y: cfg_hi_ff[1] <= csr_pwdata[W-1:0];
            tri_pkg::CSR_LOWER_Z: cfg_lo_ff[2] <= csr_pwdata[W-1:0];
            tri_pkg::CSR_UPPER_Z: cfg_hi_ff[2] <= csr_pwdata[W-1:0];
            tri_pkg::CSR_TOLERANCE: cfg_tol_ff <= csr_pwdata[F-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         tri_pkg::CSR_LOWER_X: csr_prdata = CSR_WIDTH'(cfg_lo_ff[0]);
         tri_pkg::CSR_UPPER_X: csr_prdata = CSR_WIDTH'(cfg_hi_ff[0]);
         tri_pkg::CSR_LOWER_Y: csr_prdata = CSR_WIDTH'(cfg_lo_ff[1]);
         tri_pkg::CSR_UPPER_Y: csr_prdata = CSR_WIDTH'(cfg_hi_ff[1]);
         tri_pkg::CSR_LOWER_Z: csr_prdata = CSR_WIDTH'(cfg_lo_ff[2]);
         tri_pkg::CSR_UPPER_Z: csr_prdata = CSR_WIDTH'(cfg_hi_ff[2]);
         tri_pkg::CSR_TOLERANCE: csr_prdata = CSR_WIDTH'(cfg_tol_ff);
         default: csr_prdata = '0;
      endcase
   end

   logic en;
   logic signed [W-1:0] req_corner [NC];
   logic signed [W-1:0] req_point [NA];

   assign en = !(rsp_valid && rsp_stall);
   assign req_stall = !en;

   always_comb begin
      req_corner[0] = req_corner_xlo_ylo_zlo;
      req_corner[1] = req_corner_xhi_ylo_zlo;
      req_corner[2] = req_corner_xhi_ylo_zhi;
      req_corner[3] = req_corner_xlo_ylo_zhi;
      req_corner[4] = req_corner_xlo_yhi_zlo;
      req_corner[5] = req_corner_xhi_yhi_zlo;
      req_corner[6] = req_corner_xhi_yhi_zhi;
      req_corner[7] = req_corner_xlo_yhi_zhi;
      req_point[0] = req_point_x;
      req_point[1] = req_point_y;
      req_point[2] = req_point_z;
   end

   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic signed [W-1:0] s1_corner_ff [NC];
   logic signed [W-1:0] s2_corner_ff [NC];
   logic signed [W-1:0] s3_corner_ff [NC];
   logic signed [W-1:0] s4_corner_ff [NC];
   logic signed [W:0]   s1_num_ff [NA];
   logic signed [W:0]   s1_den_ff [NA];
   logic signed [W:0]   s2_num_ff [NA];
   logic [W-1:0]        s2_den_ff [NA];
   logic                s2_deg_ff [NA];
   logic signed [W:0]   s3_num_ff [NA];
   logic [W-1:0]        s3_den_ff [NA];
   logic                s3_deg_ff [NA];
   logic                s3_le0_ff [NA];
   logic                s3_ge_ff [NA];
   logic [W+F:0]        s3_hi_ff [NA];
   logic [W+F-1:0]      s3_lo_ff [NA];
   logic                s4_bad_ff;
   tri_pkg::frac_sel_type s4_sel_ff [NA];
   logic [W-1:0]        s4_num_ff [NA];
   logic [W-1:0]        s4_den_ff [NA];

   logic                  s4_bad_in;
   tri_pkg::frac_sel_type s4_sel_in [NA];
   logic [W-1:0]          s4_num_in [NA];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_comb begin
      logic signed [W+F+1:0] lhs;
      logic signed [W+F+1:0] hi_s;
      logic signed [W+F+1:0] lo_neg;
      logic                  over;
      logic                  under;
      s4_bad_in = 1'b0;
      for (int a = 0; a < NA; a++) begin
         lhs = (W+F+2)'($signed({s3_num_ff[a], {F{1'b0}}}));
         hi_s = $signed({1'b0, s3_hi_ff[a]});
         lo_neg = -$signed({2'b00, s3_lo_ff[a]});
         over = lhs > hi_s;
         under = lhs < lo_neg;
         s4_bad_in = s4_bad_in || s3_deg_ff[a] || over || under;
         if (s3_le0_ff[a]) begin
            s4_sel_in[a] = tri_pkg::SEL_ZERO;
         end else if (s3_ge_ff[a]) begin
            s4_sel_in[a] = tri_pkg::SEL_ONE;
         end else begin
            s4_sel_in[a] = tri_pkg::SEL_DIV;
         end
         s4_num_in[a] = (s4_sel_in[a] == tri_pkg::SEL_DIV) ? s3_num_ff[a][W-1:0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      logic neg;
      if (en) begin
         for (int i = 0; i < NC; i++) begin
            s1_corner_ff[i] <= req_corner[i];
            s2_corner_ff[i] <= s1_corner_ff[i];
            s3_corner_ff[i] <= s2_corner_ff[i];
            s4_corner_ff[i] <= s3_corner_ff[i];
         end
         for (int a = 0; a < NA; a++) begin
            s1_num_ff[a] <= (W+1)'(req_point[a]) - (W+1)'(cfg_lo_ff[a]);
            s1_den_ff[a] <= (W+1)'(cfg_hi_ff[a]) - (W+1)'(cfg_lo_ff[a]);
            neg = s1_den_ff[a][W];
            s2_num_ff[a] <= neg ? -s1_num_ff[a] : s1_num_ff[a];
            s2_den_ff[a] <= neg ? W'(-s1_den_ff[a]) : s1_den_ff[a][W-1:0];
            s2_deg_ff[a] <= s1_den_ff[a] == '0;
            s3_num_ff[a] <= s2_num_ff[a];
            s3_den_ff[a] <= s2_den_ff[a];
            s3_deg_ff[a] <= s2_deg_ff[a];
            s3_le0_ff[a] <= s2_num_ff[a][W] || (s2_num_ff[a] == '0);
            s3_ge_ff[a] <= !s2_num_ff[a][W] && (s2_num_ff[a][W-1:0] >= s2_den_ff[a]);
            s3_hi_ff[a] <= (W+F+1)'({1'b1, cfg_tol_ff}) * (W+F+1)'(s2_den_ff[a]);
            s3_lo_ff[a] <= (W+F)'(cfg_tol_ff) * (W+F)'(s2_den_ff[a]);
            s4_sel_ff[a] <= s4_sel_in[a];
            s4_num_ff[a] <= s4_num_in[a];
            s4_den_ff[a] <= s3_den_ff[a];
         end
         s4_bad_ff <= s4_bad_in;
      end
   end

   logic [PW-1:0] div_in_pay, div_out_pay;
   logic          div_out_valid;
   logic [F-1:0]  div_quo [NA];

   always_comb begin
      div_in_pay = '0;
      for (int i = 0; i < NC; i++) begin
         div_in_pay[i*W +: W] = s4_corner_ff[i];
      end
      for (int a = 0; a < NA; a++) begin
         div_in_pay[NC*W + 2*a +: 2] = s4_sel_ff[a];
      end
      div_in_pay[PW-1] = s4_bad_ff;
   end

   tri_div #(
      .W (W),
      .F (F),
      .PW(PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s4_valid_ff),
      .in_num   (s4_num_ff),
      .in_den   (s4_den_ff),
      .in_pay   (div_in_pay),
      .out_valid(div_out_valid),
      .out_quo  (div_quo),
      .out_pay  (div_out_pay)
   );

   logic                s5_valid_ff;
   logic                s5_bad_ff;
   logic [F:0]          s5_f_ff [NA];
   logic signed [W-1:0] s5_corner_ff [NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NC; i++) begin
            s5_corner_ff[i] <= div_out_pay[i*W +: W];
         end
         for (int a = 0; a < NA; a++) begin
            case (tri_pkg::frac_sel_type'(div_out_pay[NC*W + 2*a +: 2]))
               tri_pkg::SEL_ONE: s5_f_ff[a] <= (F+1)'(1) << F;
               tri_pkg::SEL_DIV: s5_f_ff[a] <= {1'b0, div_quo[a]};
               default:          s5_f_ff[a] <= '0;
            endcase
         end
         s5_bad_ff <= div_out_pay[PW-1];
      end
   end

   logic signed [W-1:0] lx_a [4];
   logic signed [W-1:0] lx_b [4];
   logic signed [W-1:0] lx_r [4];
   logic [YPW-1:0]      lx_pay;
   logic                lx_valid;
   logic signed [W-1:0] ly_a [2];
   logic signed [W-1:0] ly_b [2];
   logic signed [W-1:0] ly_r [2];
   logic [ZPW-1:0]      ly_pay;
   logic                ly_valid;
   logic signed [W-1:0] lz_a [1];
   logic signed [W-1:0] lz_b [1];
   logic signed [W-1:0] lz_r [1];
   logic                lz_pay;
   logic                lz_valid;

   always_comb begin
      lx_a[0] = s5_corner_ff[0];
      lx_b[0] = s5_corner_ff[1];
      lx_a[1] = s5_corner_ff[3];
      lx_b[1] = s5_corner_ff[2];
      lx_a[2] = s5_corner_ff[4];
      lx_b[2] = s5_corner_ff[5];
      lx_a[3] = s5_corner_ff[7];
      lx_b[3] = s5_corner_ff[6];
      ly_a[0] = lx_r[0];
      ly_b[0] = lx_r[2];
      ly_a[1] = lx_r[1];
      ly_b[1] = lx_r[3];
      lz_a[0] = ly_r[0];
      lz_b[0] = ly_r[1];
   end

   tri_lerp #(
      .W    (W),
      .F    (F),
      .LANES(4),
      .PW   (YPW)
   ) u_lerp_x (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s5_valid_ff),
      .in_a     (lx_a),
      .in_b     (lx_b),
      .in_f     (s5_f_ff[0]),
      .in_pay   ({s5_f_ff[2], s5_f_ff[1], s5_bad_ff}),
      .out_valid(lx_valid),
      .out_r    (lx_r),
      .out_pay  (lx_pay)
   );

   tri_lerp #(
      .W    (W),
      .F    (F),
      .LANES(2),
      .PW   (ZPW)
   ) u_lerp_y (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (lx_valid),
      .in_a     (ly_a),
      .in_b     (ly_b),
      .in_f     (lx_pay[F+1:1]),
      .in_pay   ({lx_pay[YPW-1:F+2], lx_pay[0]}),
      .out_valid(ly_valid),
      .out_r    (ly_r),
      .out_pay  (ly_pay)
   );

   tri_lerp #(
      .W    (W),
      .F    (F),
      .LANES(1),
      .PW   (1)
   ) u_lerp_z (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (ly_valid),
      .in_a     (lz_a),
      .in_b     (lz_b),
      .in_f     (ly_pay[ZPW-1:1]),
      .in_pay   (ly_pay[0]),
      .out_valid(lz_valid),
      .out_r    (lz_r),
      .out_pay  (lz_pay)
   );

   logic                rsp_valid_ff;
   logic signed [W-1:0] rsp_interpolated_ff;
   logic                rsp_range_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lz_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_interpolated_ff <= lz_pay ? '0 : lz_r[0];
         rsp_range_error_ff <= lz_pay;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_interpolated = rsp_interpolated_ff;
   assign rsp_range_error = rsp_range_error_ff;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_range_error |-> rsp_interpolated == '0)
      else $error("range error with non-zero value");

   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && en |=> s2_valid_ff)
      else $error("request lost between first stages");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(s5_valid_ff) && $stable(s4_valid_ff))
      else $error("pipeline moved while stalled");

endmodule

FILE: dv/trilinear_interpolator_top_tb.sv
`timescale 1ns / 100ps

module trilinear_interpolator_top_tb;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 48;
   localparam int RANDOM_PER_PHASE = 205;
   localparam int NUM_PHASES = 8;
   localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
   localparam longint ONE = 64'sd65536;

   typedef struct {
      logic signed [31:0] corner [tri_pkg::NUM_CORNERS];
      logic signed [31:0] pt [tri_pkg::NUM_AXES];
      bit                 fixed_exp;
      logic signed [31:0] val;
      bit                 err;
   } query_type;

   typedef struct {
      logic signed [31:0] val;
      bit                 err;
   } blend_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [31:0] req_corner [tri_pkg::NUM_CORNERS];
   logic signed [31:0] req_pt [tri_pkg::NUM_AXES];
   logic rsp_valid;
   logic rsp_stall;
   logic signed [31:0] rsp_interpolated;
   logic rsp_range_error;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic csr_pready;

   trilinear_interpolator_top u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_corner_xlo_ylo_zlo (req_corner[0]),
      .req_corner_xhi_ylo_zlo (req_corner[1]),
      .req_corner_xhi_ylo_zhi (req_corner[2]),
      .req_corner_xlo_ylo_zhi (req_corner[3]),
      .req_corner_xlo_yhi_zlo (req_corner[4]),
      .req_corner_xhi_yhi_zlo (req_corner[5]),
      .req_corner_xhi_yhi_zhi (req_corner[6]),
      .req_corner_xlo_yhi_zhi (req_corner[7]),
      .req_point_x            (req_pt[0]),
      .req_point_y            (req_pt[1]),
      .req_point_z            (req_pt[2]),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_interpolated       (rsp_interpolated),
      .rsp_range_error        (rsp_range_error),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   // cell bounds per axis and tolerance, as the block holds them
   longint cell_lo [tri_pkg::NUM_AXES];
   longint cell_hi [tri_pkg::NUM_AXES];
   longint tol;

   query_type pending_q [$];
   blend_type blend_q [$];
   int unsigned req_taken;
   int unsigned n_mismatch;
   int unsigned quiet_cycles;
   int stall_pct;
   int gap_pct;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit axis_frac(input longint p, input longint lo, input longint hi,
                                    output longint f);
      longint num, den;
      num = p - lo;
      den = hi - lo;
      f = 0;
      if (den == 0) return 1'b1;
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      if (num * ONE > (ONE + tol) * den || num * ONE < -tol * den) return 1'b1;
      if (num <= 0) f = 0;
      else if (num >= den) f = ONE;
      else f = (num * ONE) / den;
      return 1'b0;
   endfunction

   function automatic longint lerp_q16(input longint a, input longint b, input longint f);
      longint acc;
      acc = a * (ONE - f) + b * f + (ONE >>> 1);
      return acc >>> 16;
   endfunction

   function automatic blend_type blend_cell(input query_type q);
      blend_type r;
      longint f [tri_pkg::NUM_AXES];
      longint c [tri_pkg::NUM_CORNERS];
      longint c00, c01, c10, c11, c0, c1, v;
      bit bad;
      bad = 1'b0;
      for (int i = 0; i < tri_pkg::NUM_AXES; i++)
         bad |= axis_frac(longint'(q.pt[i]), cell_lo[i], cell_hi[i], f[i]);
      r.val = '0;
      r.err = bad;
      if (!bad) begin
         for (int i = 0; i < tri_pkg::NUM_CORNERS; i++) c[i] = longint'(q.corner[i]);
         c00 = lerp_q16(c[0], c[1], f[0]);
         c01 = lerp_q16(c[3], c[2], f[0]);
         c10 = lerp_q16(c[4], c[5], f[0]);
         c11 = lerp_q16(c[7], c[6], f[0]);
         c0 = lerp_q16(c00, c10, f[1]);
         c1 = lerp_q16(c01, c11, f[1]);
         v = lerp_q16(c0, c1, f[2]);
         if (v > longint'(Q_MAX)) v = longint'(Q_MAX);
         if (v < longint'(Q_MIN)) v = longint'(Q_MIN);
         r.val = v[31:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      n_mismatch++;
   endtask

   always @(posedge clock) begin
      query_type q;
      blend_type e;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            q = pending_q.pop_front();
            if (q.fixed_exp) begin
               e.val = q.val;
               e.err = q.err;
            end else begin
               e = blend_cell(q);
            end
            blend_q.push_back(e);
            req_taken++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (blend_q.size() == 0) begin
               report_mismatch("response with no request outstanding");
            end else begin
               e = blend_q.pop_front();
               if (rsp_interpolated !== e.val)
                  report_mismatch($sformatf("interpolated %h, want %h",
                                            rsp_interpolated, e.val));
               if (rsp_range_error !== e.err)
                  report_mismatch($sformatf("range_error %b, want %b",
                                            rsp_range_error, e.err));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall = !reset && ($urandom_range(99) < stall_pct);
   end

   task automatic csr_write(input tri_pkg::csr_reg_type idx, input logic [31:0] value);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = 5'(idx) << 2;
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      case (idx)
         tri_pkg::CSR_LOWER_X: cell_lo[0] = longint'(signed'(value));
         tri_pkg::CSR_UPPER_X: cell_hi[0] = longint'(signed'(value));
         tri_pkg::CSR_LOWER_Y: cell_lo[1] = longint'(signed'(value));
         tri_pkg::CSR_UPPER_Y: cell_hi[1] = longint'(signed'(value));
         tri_pkg::CSR_LOWER_Z: cell_lo[2] = longint'(signed'(value));
         tri_pkg::CSR_UPPER_Z: cell_hi[2] = longint'(signed'(value));
         tri_pkg::CSR_TOLERANCE: tol = longint'(value[15:0]);
         default: ;
      endcase
   endtask

   task automatic set_cell(input logic [31:0] b [6], input logic [31:0] t);
      csr_write(tri_pkg::CSR_LOWER_X, b[0]);
      csr_write(tri_pkg::CSR_UPPER_X, b[1]);
      csr_write(tri_pkg::CSR_LOWER_Y, b[2]);
      csr_write(tri_pkg::CSR_UPPER_Y, b[3]);
      csr_write(tri_pkg::CSR_LOWER_Z, b[4]);
      csr_write(tri_pkg::CSR_UPPER_Z, b[5]);
      csr_write(tri_pkg::CSR_TOLERANCE, t);
   endtask

   task automatic send(input query_type q);
      int unsigned seen;
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_corner = q.corner;
      req_pt = q.pt;
      pending_q.push_back(q);
      req_valid = 1'b1;
      seen = req_taken;
      do @(negedge clock); while (req_taken == seen);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (blend_q.size() != 0 || pending_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic query_type ramp_query(input logic signed [31:0] base,
                                            input logic signed [31:0] step,
                                            input longint px, input longint py,
                                            input longint pz, input bit fixed_exp,
                                            input logic signed [31:0] val, input bit err);
      query_type q;
      for (int i = 0; i < tri_pkg::NUM_CORNERS; i++) q.corner[i] = base + step * i;
      q.pt[0] = px[31:0];
      q.pt[1] = py[31:0];
      q.pt[2] = pz[31:0];
      q.fixed_exp = fixed_exp;
      q.val = val;
      q.err = err;
      return q;
   endfunction

   function automatic logic [31:0] rand_point(input int axis);
      longint lo, den, f, p;
      int r;
      lo = cell_lo[axis];
      den = cell_hi[axis] - lo;
      r = $urandom_range(99);
      if (den == 0 || r < 10) return $urandom;
      if (r < 20) f = -tol - longint'($urandom_range(2)) + 1;
      else if (r < 30) f = ONE + tol - longint'($urandom_range(2)) + 1;
      else if (r < 40) f = ($urandom_range(1) ? ONE : 0) + longint'($urandom_range(2)) - 1;
      else f = longint'($urandom_range(65536));
      p = lo + ((den * f) >>> 16);
      if (p > longint'(Q_MAX) || p < longint'(Q_MIN)) p = lo;
      return p[31:0];
   endfunction

   function automatic query_type rand_query();
      query_type q;
      for (int i = 0; i < tri_pkg::NUM_CORNERS; i++) begin
         case ($urandom_range(9))
            0: q.corner[i] = Q_MAX;
            1: q.corner[i] = Q_MIN;
            default: q.corner[i] = $urandom;
         endcase
      end
      for (int i = 0; i < tri_pkg::NUM_AXES; i++) q.pt[i] = rand_point(i);
      q.fixed_exp = 1'b0;
      q.val = '0;
      q.err = 1'b0;
      return q;
   endfunction

   initial begin
      query_type directed [$];
      logic [31:0] b [6];
      int mode;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_corner = '{default: '0};
      req_pt = '{default: '0};
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stall_pct = 0;
      gap_pct = 0;
      req_taken = 0;
      n_mismatch = 0;
      cell_lo = '{0, 0, 0};
      cell_hi = '{ONE, ONE, ONE};
      tol = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners (i+1).0 in the reset cell; the cell corners pick single values
      directed.push_back(ramp_query(ONE_Q, ONE_Q, 0, 0, 0, 1, 32'sh0001_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, ONE, 0, 0, 1, 32'sh0002_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, ONE, 0, ONE, 1, 32'sh0003_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, 0, 0, ONE, 1, 32'sh0004_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, 0, ONE, 0, 1, 32'sh0005_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, ONE, ONE, 0, 1, 32'sh0006_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, ONE, ONE, ONE, 1, 32'sh0007_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, 0, ONE, ONE, 1, 32'sh0008_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, ONE + 1, ONE, ONE, 1, 32'sh0007_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, -1, 0, 0, 1, 32'sh0001_0000, 0));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, ONE + 2, 0, 0, 1, 0, 1));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, 0, -2, 0, 1, 0, 1));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, 0, 0, longint'(Q_MIN), 1, 0, 1));
      directed.push_back(ramp_query(ONE_Q, ONE_Q, longint'(Q_MAX), longint'(Q_MIN), 0, 1,
                                    0, 1));
      directed.push_back(ramp_query(Q_MAX, 0, 32768, 32768, 32768, 1, Q_MAX, 0));
      directed.push_back(ramp_query(Q_MIN, 0, 12345, 54321, 777, 1, Q_MIN, 0));
      directed.push_back(ramp_query(Q_MIN, Q_MAX, 32768, 32768, 32768, 0, 0, 0));
      directed.push_back(ramp_query(Q_MAX, 32'sh7654_3210, 65535, 1, 40000, 0, 0, 0));
      directed.push_back(ramp_query(32'sh1234_5678, -32'sh0abc_def1, 1, 65535, 3, 0, 0, 0));
      foreach (directed[i]) send(directed[i]);
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: ;
            1: begin
               b = '{Q_MIN, Q_MAX, -32'sd6553600, 32'sd196608, -32'sd5, 32'sd7};
               set_cell(b, 32'd0);
            end
            2: begin
               b = '{32'sd65536, 32'sd0, 32'sd300000, -32'sd300000, 32'sd9, 32'sd2};
               set_cell(b, 32'd65535);
            end
            3: begin
               b = '{32'sd12345, 32'sd12345, $urandom, $urandom, $urandom, $urandom};
               set_cell(b, $urandom);
            end
            4: begin
               b = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
               set_cell(b, $urandom);
               csr_write(tri_pkg::CSR_UNUSED, $urandom);
            end
            5: begin
               b = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX};
               set_cell(b, 32'd65535);
            end
            default: begin
               for (int i = 0; i < 6; i++)
                  b[i] = $urandom_range(1) ? $urandom : $signed($urandom_range(4, 0) << 16);
               set_cell(b, $urandom_range(1) ? $urandom_range(16) : $urandom);
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % 50 == 0) begin
               mode = $urandom_range(3);
               gap_pct = (mode == 1) ? 69 : (mode == 3) ? 28 : 0;
               stall_pct = (mode == 2) ? 69 : (mode == 3) ? 28 : 0;
            end
            send(rand_query());
         end
         drain();
      end

      stall_pct = 0;
      if (n_mismatch == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
